### rtl/lqgrc_pkg.sv
`default_nettype none

package lqgrc_pkg;

  // Q16.16 word, accumulator and raw product widths.
  localparam int unsigned QW     = 32;
  localparam int unsigned ACC_W  = 36;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned SH_W   = PROD_W - 16;
  localparam int unsigned DRV_W  = 18;
  localparam int unsigned LIM_W  = 31;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_AW = 6;
  localparam int unsigned IDX_W  = 3;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_A01_A02 = 3'd0;
  localparam logic [IDX_W-1:0] REG_A11_A12 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B0_B1   = 3'd2;
  localparam logic [IDX_W-1:0] REG_K0_K1   = 3'd3;
  localparam logic [IDX_W-1:0] REG_K2      = 3'd4;
  localparam logic [IDX_W-1:0] REG_LQR     = 3'd5;
  localparam logic [IDX_W-1:0] REG_BLIM    = 3'd6;

  // Sequencer steps. Each step from STEP_B0U to STEP_TS issues one product, and
  // each step from STEP_A01X1 to STEP_BIAS retires the product issued in the step before it.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_B0U    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_A01X1  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_A02X2  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_B1U    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_A11X1  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_A12X2  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_K0I    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_K1I    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_K2I    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_UU     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_L0E    = 4'd10;
  localparam logic [STEP_W-1:0] STEP_U2U2   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_L1N1   = 4'd12;
  localparam logic [STEP_W-1:0] STEP_TS     = 4'd13;
  localparam logic [STEP_W-1:0] STEP_BIAS   = 4'd14;
  localparam logic [STEP_W-1:0] STEP_DRIVE  = 4'd15;

  localparam logic signed [QW-1:0] ONE_Q16 = 32'sd65536;

  typedef struct packed {
    logic signed [QW-1:0] a01;
    logic signed [QW-1:0] a02;
    logic signed [QW-1:0] a11;
    logic signed [QW-1:0] a12;
    logic signed [QW-1:0] b0;
    logic signed [QW-1:0] b1;
    logic signed [QW-1:0] k0;
    logic signed [QW-1:0] k1;
    logic signed [QW-1:0] k2;
    logic signed [QW-1:0] l0;
    logic signed [QW-1:0] l1;
    logic [LIM_W-1:0]     blim;
  } cfg_t;

  typedef struct packed {
    logic              capture;
    logic              run;
    logic [STEP_W-1:0] step;
    logic              commit;
  } cmd_t;

  // Saturate a 48-bit signed value to 32 bits.
  function automatic logic signed [QW-1:0] sat48(input logic signed [SH_W-1:0] v);
    logic signed [SH_W-1:0] hi;
    logic signed [SH_W-1:0] lo;
    hi = {{(SH_W-QW+1){1'b0}}, {(QW-1){1'b1}}};
    lo = {{(SH_W-QW+1){1'b1}}, {(QW-1){1'b0}}};
    if (v > hi) begin
      sat48 = {1'b0, {(QW-1){1'b1}}};
    end else if (v < lo) begin
      sat48 = {1'b1, {(QW-1){1'b0}}};
    end else begin
      sat48 = v[QW-1:0];
    end
  endfunction

  // Saturate an accumulator value to 32 bits.
  function automatic logic signed [QW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    sat_acc = sat48({{(SH_W-ACC_W){v[ACC_W-1]}}, v});
  endfunction

  // Sign-extend a Q16.16 word to accumulator width.
  function automatic logic signed [ACC_W-1:0] ext(input logic signed [QW-1:0] v);
    ext = {{(ACC_W-QW){v[QW-1]}}, v};
  endfunction

  // Round half up, drop 16 fraction bits and saturate a raw product.
  function automatic logic signed [QW-1:0] qround(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = p + 64'sd32768;
    qround = sat48(r[PROD_W-1:16]);
  endfunction

endpackage

`default_nettype wire

### rtl/lqgrc_regs.sv
`default_nettype none

module lqgrc_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lqgrc_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [lqgrc_pkg::CFG_DW-1:0]  pwdata,
  output logic      [lqgrc_pkg::CFG_DW-1:0]  prdata,
  output logic                               pready,
  output lqgrc_pkg::cfg_t                    cfg
);

  lqgrc_pkg::cfg_t cfg_r;
  lqgrc_pkg::cfg_t cfg_nxt;
  logic [lqgrc_pkg::IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[lqgrc_pkg::CFG_AW-1:lqgrc_pkg::CFG_AW-lqgrc_pkg::IDX_W];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        lqgrc_pkg::REG_A01_A02: begin
          cfg_nxt.a01 = pwdata[63:32];
          cfg_nxt.a02 = pwdata[31:0];
        end
        lqgrc_pkg::REG_A11_A12: begin
          cfg_nxt.a11 = pwdata[63:32];
          cfg_nxt.a12 = pwdata[31:0];
        end
        lqgrc_pkg::REG_B0_B1: begin
          cfg_nxt.b0 = pwdata[63:32];
          cfg_nxt.b1 = pwdata[31:0];
        end
        lqgrc_pkg::REG_K0_K1: begin
          cfg_nxt.k0 = pwdata[63:32];
          cfg_nxt.k1 = pwdata[31:0];
        end
        lqgrc_pkg::REG_K2: begin
          cfg_nxt.k2 = pwdata[31:0];
        end
        lqgrc_pkg::REG_LQR: begin
          cfg_nxt.l0 = pwdata[63:32];
          cfg_nxt.l1 = pwdata[31:0];
        end
        lqgrc_pkg::REG_BLIM: begin
          cfg_nxt.blim = pwdata[lqgrc_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      lqgrc_pkg::REG_A01_A02: prdata = {cfg_r.a01, cfg_r.a02};
      lqgrc_pkg::REG_A11_A12: prdata = {cfg_r.a11, cfg_r.a12};
      lqgrc_pkg::REG_B0_B1:   prdata = {cfg_r.b0, cfg_r.b1};
      lqgrc_pkg::REG_K0_K1:   prdata = {cfg_r.k0, cfg_r.k1};
      lqgrc_pkg::REG_K2:      prdata = {32'd0, cfg_r.k2};
      lqgrc_pkg::REG_LQR:     prdata = {cfg_r.l0, cfg_r.l1};
      lqgrc_pkg::REG_BLIM:    prdata = {33'd0, cfg_r.blim};
      default:                prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/lqgrc_ctrl.sv
`default_nettype none

module lqgrc_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output lqgrc_pkg::cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state_r, state_nxt;
  logic [lqgrc_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          slot_free;
  logic                          last_step;
  logic                          commit;
  logic                          accept;

  assign slot_free = !out_valid_r || !out_stall;
  assign last_step = (state_r == ST_RUN) && (step_r == lqgrc_pkg::STEP_DRIVE);
  assign commit    = last_step && slot_free;
  // A new beat is taken when idle, or in the same cycle the previous one retires.
  assign in_stall  = !((state_r == ST_IDLE) || commit);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          step_nxt  = lqgrc_pkg::STEP_B0U;
        end
      end
      ST_RUN: begin
        if (step_r != lqgrc_pkg::STEP_DRIVE) begin
          step_nxt = step_r + 1'b1;
        end else if (commit) begin
          step_nxt  = lqgrc_pkg::STEP_B0U;
          state_nxt = accept ? ST_RUN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= lqgrc_pkg::STEP_B0U;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd.capture = accept;
    cmd.run     = (state_r == ST_RUN);
    cmd.step    = step_r;
    cmd.commit  = commit;
  end

endmodule

`default_nettype wire

### rtl/lqgrc_datapath.sv
`default_nettype none

module lqgrc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lqgrc_pkg::cmd_t                     cmd,
  input  wire lqgrc_pkg::cfg_t                     cfg,
  input  wire logic signed [lqgrc_pkg::QW-1:0]     in_measured_rate,
  input  wire logic signed [lqgrc_pkg::QW-1:0]     in_target_rate,
  output logic signed [lqgrc_pkg::DRV_W-1:0]       out_drive,
  output logic signed [lqgrc_pkg::QW-1:0]          out_est_rate_out,
  output logic signed [lqgrc_pkg::QW-1:0]          out_est_torque_out,
  output logic signed [lqgrc_pkg::QW-1:0]          out_est_bias_out
);

  localparam int unsigned QW    = lqgrc_pkg::QW;
  localparam int unsigned ACC_W = lqgrc_pkg::ACC_W;
  localparam int unsigned DRV_W = lqgrc_pkg::DRV_W;

  // Estimator state.
  logic signed [QW-1:0]    x0_r, x1_r, x2_r;
  logic signed [DRV_W-1:0] u_r;

  // Captured inputs and intermediates.
  logic signed [QW-1:0] meas_r, target_r;
  logic signed [QW-1:0] p0_r, p1_r, innov_r, n0_r, n1_r, err_r, t_r, u2_r, scale_r, n2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [lqgrc_pkg::PROD_W-1:0] prod_r;

  logic signed [QW-1:0] opa, opb, u_w, q, scale_c, n2_c, drive_s;
  logic signed [ACC_W-1:0] scale_sum, drive_sum;
  logic signed [QW:0] q33, lim33;
  logic signed [DRV_W-1:0] drive_c;

  assign u_w = {{(QW-DRV_W){u_r[DRV_W-1]}}, u_r};
  assign q   = lqgrc_pkg::qround(prod_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.step)
      lqgrc_pkg::STEP_B0U:   begin opa = cfg.b0;  opb = u_w;     end
      lqgrc_pkg::STEP_A01X1: begin opa = cfg.a01; opb = x1_r;    end
      lqgrc_pkg::STEP_A02X2: begin opa = cfg.a02; opb = x2_r;    end
      lqgrc_pkg::STEP_B1U:   begin opa = cfg.b1;  opb = u_w;     end
      lqgrc_pkg::STEP_A11X1: begin opa = cfg.a11; opb = x1_r;    end
      lqgrc_pkg::STEP_A12X2: begin opa = cfg.a12; opb = x2_r;    end
      lqgrc_pkg::STEP_K0I:   begin opa = cfg.k0;  opb = innov_r; end
      lqgrc_pkg::STEP_K1I:   begin opa = cfg.k1;  opb = innov_r; end
      lqgrc_pkg::STEP_K2I:   begin opa = cfg.k2;  opb = innov_r; end
      lqgrc_pkg::STEP_UU:    begin opa = u_w;     opb = u_w;     end
      lqgrc_pkg::STEP_L0E:   begin opa = cfg.l0;  opb = err_r;   end
      lqgrc_pkg::STEP_U2U2:  begin opa = u2_r;    opb = u2_r;    end
      lqgrc_pkg::STEP_L1N1:  begin opa = cfg.l1;  opb = n1_r;    end
      lqgrc_pkg::STEP_TS:    begin opa = t_r;     opb = scale_r; end
      default:               begin opa = '0;      opb = '0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
  end

  // Bias scale, clamped to 0..1.
  always_comb begin
    scale_sum = lqgrc_pkg::ext(lqgrc_pkg::ONE_Q16) - lqgrc_pkg::ext(q);
    scale_c   = lqgrc_pkg::sat_acc(scale_sum);
    if (scale_c < 0) begin
      scale_c = '0;
    end else if (scale_c > lqgrc_pkg::ONE_Q16) begin
      scale_c = lqgrc_pkg::ONE_Q16;
    end
  end

  // Bias clamp to the symmetric limit.
  always_comb begin
    q33   = {q[QW-1], q};
    lim33 = {2'b00, cfg.blim};
    if (q33 > lim33) begin
      n2_c = lim33[QW-1:0];
    end else if (q33 < -lim33) begin
      n2_c = -lim33[QW-1:0];
    end else begin
      n2_c = q;
    end
  end

  // Final drive: the accumulator holds the negated LQR terms.
  always_comb begin
    drive_sum = acc_r + lqgrc_pkg::ext(n2_r);
    drive_s   = lqgrc_pkg::sat_acc(drive_sum);
    if (drive_s > lqgrc_pkg::ONE_Q16) begin
      drive_c = lqgrc_pkg::ONE_Q16[DRV_W-1:0];
    end else if (drive_s < -lqgrc_pkg::ONE_Q16) begin
      drive_c = -lqgrc_pkg::ONE_Q16[DRV_W-1:0];
    end else begin
      drive_c = drive_s[DRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_r   <= in_measured_rate;
      target_r <= in_target_rate;
    end
    if (cmd.run) begin
      case (cmd.step)
        lqgrc_pkg::STEP_B0U:   acc_r <= lqgrc_pkg::ext(x0_r);
        lqgrc_pkg::STEP_A01X1: acc_r <= acc_r + lqgrc_pkg::ext(q);
        lqgrc_pkg::STEP_A02X2: acc_r <= acc_r + lqgrc_pkg::ext(q);
        lqgrc_pkg::STEP_B1U:   p0_r  <= lqgrc_pkg::sat_acc(acc_r + lqgrc_pkg::ext(q));
        lqgrc_pkg::STEP_A11X1: begin
          acc_r   <= lqgrc_pkg::ext(q);
          innov_r <= lqgrc_pkg::sat_acc(lqgrc_pkg::ext(p0_r) - lqgrc_pkg::ext(meas_r));
        end
        lqgrc_pkg::STEP_A12X2: acc_r <= acc_r + lqgrc_pkg::ext(q);
        lqgrc_pkg::STEP_K0I:   p1_r  <= lqgrc_pkg::sat_acc(acc_r + lqgrc_pkg::ext(q));
        lqgrc_pkg::STEP_K1I:
          n0_r <= lqgrc_pkg::sat_acc(lqgrc_pkg::ext(p0_r) - lqgrc_pkg::ext(q));
        lqgrc_pkg::STEP_K2I: begin
          n1_r  <= lqgrc_pkg::sat_acc(lqgrc_pkg::ext(p1_r) - lqgrc_pkg::ext(q));
          err_r <= lqgrc_pkg::sat_acc(lqgrc_pkg::ext(n0_r) - lqgrc_pkg::ext(target_r));
        end
        lqgrc_pkg::STEP_UU:
          t_r <= lqgrc_pkg::sat_acc(lqgrc_pkg::ext(x2_r) - lqgrc_pkg::ext(q));
        lqgrc_pkg::STEP_L0E:   u2_r    <= q;
        lqgrc_pkg::STEP_U2U2:  acc_r   <= -lqgrc_pkg::ext(q);
        lqgrc_pkg::STEP_L1N1:  scale_r <= scale_c;
        lqgrc_pkg::STEP_TS:    acc_r   <= acc_r - lqgrc_pkg::ext(q);
        lqgrc_pkg::STEP_BIAS:  n2_r    <= n2_c;
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      out_drive          <= drive_c;
      out_est_rate_out   <= n0_r;
      out_est_torque_out <= n1_r;
      out_est_bias_out   <= n2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      x1_r <= '0;
      x2_r <= '0;
      u_r  <= '0;
    end else if (cmd.commit) begin
      x0_r <= n0_r;
      x1_r <= n1_r;
      x2_r <= n2_r;
      u_r  <= drive_c;
    end
  end

endmodule

`default_nettype wire

### rtl/lqg_rate_control_step.sv
// LQG rate controller, one gyro sample per input beat, Q16.16 (drive Q2.16).
// The input channel (in_valid, in_stall) carries the measured rate and the
// setpoint. Each beat yields exactly one result beat on the output channel
// (out_valid, out_stall): the new drive, clamped to -1..1, and the updated
// rate, torque and bias estimates.
// Each beat runs through the sequencer steps around the single shared 32x32
// multiplier: fourteen rounded products go through it one per cycle, followed
// by the bias clamp and the drive sum.
// A new input beat is taken when the block is idle, or in the very cycle the
// previous beat retires, so back-to-back samples follow with no idle step in
// between. The result sits in an output register; while it is full
// and the receiver holds out_stall, a finished beat waits in the last step
// and in_stall stays high, so nothing is lost or overwritten.
// Gains are written over the APB-style port (64-bit registers at 8*index,
// pready always high) only while no beat is in flight, a rule for the user
// not enforced by the block. Synchronous active-low rst_n zeroes all gains,
// the three estimates and the stored drive and empties the output register.
`default_nettype none

module lqg_rate_control_step (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [lqgrc_pkg::QW-1:0]     in_measured_rate,
  input  wire logic signed [lqgrc_pkg::QW-1:0]     in_target_rate,
  // Result channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [lqgrc_pkg::DRV_W-1:0]       out_drive,
  output logic signed [lqgrc_pkg::QW-1:0]          out_est_rate_out,
  output logic signed [lqgrc_pkg::QW-1:0]          out_est_torque_out,
  output logic signed [lqgrc_pkg::QW-1:0]          out_est_bias_out,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [lqgrc_pkg::CFG_AW-1:0]        paddr,
  input  wire logic [lqgrc_pkg::CFG_DW-1:0]        pwdata,
  output logic      [lqgrc_pkg::CFG_DW-1:0]        prdata,
  output logic                                     pready
);

  lqgrc_pkg::cfg_t cfg;
  lqgrc_pkg::cmd_t cmd;

  // Gain and limit registers.
  lqgrc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Step sequencer and handshake control.
  lqgrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Shared multiplier, accumulator, estimator state and result register.
  lqgrc_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg),
    .in_measured_rate   (in_measured_rate),
    .in_target_rate     (in_target_rate),
    .out_drive          (out_drive),
    .out_est_rate_out   (out_est_rate_out),
    .out_est_torque_out (out_est_torque_out),
    .out_est_bias_out   (out_est_bias_out)
  );

endmodule

`default_nettype wire
